// ===== src/dmxe_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DMX512 frame symbol encoder package
// Shared payload types, register map, symbol index map and helper functions.
// -----------------------------------------------------------------------------
package dmxe_pkg;

	// Largest number of data slots in one frame.
	localparam int unsigned MAX_SLOTS = 512;
	localparam int unsigned SLOT_CNT_W = 10;

	// Register map: index of each register in the configuration space.
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_BREAK = 2'd0;
	localparam logic [1:0] REG_MAB   = 2'd1;
	localparam logic [1:0] REG_BIT   = 2'd2;

	// Reset values of the duration registers.
	localparam logic [15:0] BREAK_RESET = 16'd176;
	localparam logic [15:0] MAB_RESET   = 16'd12;
	localparam logic [15:0] BIT_RESET   = 16'd4;

	localparam logic [7:0] START_CODE = 8'h00;

	// Symbol index map of one command: break, mark after break, start code
	// slot, then the data slot.
	localparam logic [4:0] IDX_BREAK    = 5'd0;
	localparam logic [4:0] IDX_MAB      = 5'd1;
	localparam logic [4:0] IDX_SC_FIRST = 5'd2;
	localparam logic [4:0] IDX_SC_LAST  = 5'd12;
	localparam logic [4:0] IDX_DT_FIRST = 5'd13;
	localparam logic [4:0] IDX_DT_LAST  = 5'd23;

	// Input item.
	typedef struct packed {
		logic [7:0] slot_byte;
		logic       frame_start;
		logic       header_only;
	} in_item_t;

	// Result item: one line symbol.
	typedef struct packed {
		logic        line_level;
		logic [15:0] duration;
		logic        last_symbol;
	} out_item_t;

	// Work queued between the front and the back.
	typedef struct packed {
		logic       header;
		logic       data;
		logic [7:0] slot_byte;
	} cmd_t;

	// Duration settings seen by the back.
	typedef struct packed {
		logic [15:0] break_ticks;
		logic [15:0] mab_ticks;
		logic [15:0] bit_ticks;
	} cfg_t;

	// Queue status between the queue and its neighbors.
	typedef struct packed {
		logic [1:0] count;
		logic       full;
		logic       empty;
		logic       push;
		logic       pop;
	} q_stat_t;

	// A zero duration is stretched to one tick.
	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		at_least_one = (v == 16'd0) ? 16'd1 : v;
	endfunction

	// Level of position pos within a slot: start bit, eight data bits LSB
	// first, two stop bits.
	function automatic logic slot_level(input logic [7:0] b, input logic [3:0] pos);
		logic lvl;
		lvl = 1'b1;
		if (pos == 4'd0) begin
			lvl = 1'b0;
		end else if (pos <= 4'd8) begin
			lvl = b[3'(pos - 4'd1)];
		end
		slot_level = lvl;
	endfunction

endpackage

// ===== src/dmxe_front.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DMX512 encoder front
// Accepts input items, tracks frame state and turns each item into a command
// for the back, dropping items that cause no symbol.
// -----------------------------------------------------------------------------
module dmxe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dmxe_pkg::in_item_t  in_item,
	input  logic                q_full,
	output logic                cmd_push,
	output dmxe_pkg::cmd_t      cmd
);

	logic [dmxe_pkg::SLOT_CNT_W-1:0] slot_count_q;
	logic                            in_frame_q;
	logic                            accept;
	logic                            room;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the item against the frame state.
	always_comb begin
		logic [dmxe_pkg::SLOT_CNT_W-1:0] cnt_eff;
		cnt_eff = in_item.frame_start ? '0 : slot_count_q;
		room = cnt_eff < dmxe_pkg::SLOT_CNT_W'(dmxe_pkg::MAX_SLOTS);
		cmd.header    = in_item.frame_start;
		cmd.slot_byte = in_item.slot_byte;
		if (in_item.frame_start) begin
			cmd.data = !in_item.header_only && room;
		end else begin
			cmd.data = in_frame_q && room;
		end
	end

	assign cmd_push = accept && (cmd.header || cmd.data);

	// Frame state updates on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			in_frame_q   <= 1'b0;
		end else if (accept) begin
			if (in_item.frame_start) begin
				in_frame_q   <= 1'b1;
				slot_count_q <= cmd.data ? dmxe_pkg::SLOT_CNT_W'(1) : '0;
			end else if (cmd.data) begin
				slot_count_q <= slot_count_q + dmxe_pkg::SLOT_CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/dmxe_queue.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DMX512 encoder command queue
// Two-entry queue that decouples the front from the back.
// -----------------------------------------------------------------------------
module dmxe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dmxe_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output dmxe_pkg::cmd_t      head,
	output dmxe_pkg::q_stat_t   stat
);

	dmxe_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign stat.push  = push;
	assign stat.pop   = pop;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/dmxe_back.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DMX512 encoder back
// Steps through the symbols of the command at the queue head into an output
// register, one symbol per cycle unless the held output is not taken.
// -----------------------------------------------------------------------------
module dmxe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dmxe_pkg::cfg_t      cfg,
	input  dmxe_pkg::cmd_t      head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output dmxe_pkg::out_item_t out_item
);

	logic                first_q;
	logic [4:0]          idx_q;
	logic                out_valid_q;
	dmxe_pkg::out_item_t out_item_q;
	logic [4:0]          cur_idx;
	logic [4:0]          end_idx;
	logic                adv;
	dmxe_pkg::out_item_t sym;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign cur_idx = first_q ? (head.header ? dmxe_pkg::IDX_BREAK : dmxe_pkg::IDX_DT_FIRST)
	                         : idx_q;
	assign end_idx = head.data ? dmxe_pkg::IDX_DT_LAST : dmxe_pkg::IDX_SC_LAST;
	assign adv     = head_valid && (!out_valid_q || out_ready);
	assign pop     = adv && (cur_idx == end_idx);

	// Symbol at the current index.
	always_comb begin
		sym.last_symbol = (cur_idx == end_idx);
		if (cur_idx == dmxe_pkg::IDX_BREAK) begin
			sym.line_level = 1'b0;
			sym.duration   = dmxe_pkg::at_least_one(cfg.break_ticks);
		end else if (cur_idx == dmxe_pkg::IDX_MAB) begin
			sym.line_level = 1'b1;
			sym.duration   = dmxe_pkg::at_least_one(cfg.mab_ticks);
		end else if (cur_idx <= dmxe_pkg::IDX_SC_LAST) begin
			sym.line_level = dmxe_pkg::slot_level(dmxe_pkg::START_CODE,
				4'(cur_idx - dmxe_pkg::IDX_SC_FIRST));
			sym.duration   = dmxe_pkg::at_least_one(cfg.bit_ticks);
		end else begin
			sym.line_level = dmxe_pkg::slot_level(head.slot_byte,
				4'(cur_idx - dmxe_pkg::IDX_DT_FIRST));
			sym.duration   = dmxe_pkg::at_least_one(cfg.bit_ticks);
		end
	end

	// Sequencer index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			idx_q   <= '0;
		end else if (adv) begin
			first_q <= pop;
			idx_q   <= cur_idx + 5'd1;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= sym;
		end
	end

endmodule

// ===== src/dmx512_frame_symbol_encoder.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DMX512 frame symbol encoder
// Turns DMX512 slot bytes into timed line symbols (level and duration).
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   in_item (slot_byte, frame_start, header_only)
// out       output     out_valid/out_ready out_item (line_level, duration, last_symbol)
// cfg       input      APB psel/penable    paddr, pwdata, prdata (break, mab, bit ticks)
//
// The back emits one symbol per cycle unless the output stalls: a data slot
// is 11 symbols, a frame start 13 more for break, mark after break and start
// code; that sequencer sets the rate. Items that cause no symbol are accepted
// and dropped by the front without entering the queue. Reset clears frame
// state, queue and output valid, and loads the default durations. A two-entry
// queue lets the front keep accepting until it fills while the output stalls.
module dmx512_frame_symbol_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  dmxe_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output dmxe_pkg::out_item_t            out_item,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dmxe_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	dmxe_pkg::cfg_t    cfg_q;
	dmxe_pkg::cmd_t    push_cmd;
	dmxe_pkg::cmd_t    head;
	dmxe_pkg::q_stat_t q_stat;
	logic              cmd_push;
	logic              pop;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.break_ticks <= dmxe_pkg::BREAK_RESET;
			cfg_q.mab_ticks   <= dmxe_pkg::MAB_RESET;
			cfg_q.bit_ticks   <= dmxe_pkg::BIT_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				dmxe_pkg::REG_BREAK: cfg_q.break_ticks <= pwdata[15:0];
				dmxe_pkg::REG_MAB:   cfg_q.mab_ticks   <= pwdata[15:0];
				dmxe_pkg::REG_BIT:   cfg_q.bit_ticks   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_idx)
			dmxe_pkg::REG_BREAK: prdata = {16'd0, cfg_q.break_ticks};
			dmxe_pkg::REG_MAB:   prdata = {16'd0, cfg_q.mab_ticks};
			dmxe_pkg::REG_BIT:   prdata = {16'd0, cfg_q.bit_ticks};
			default:             prdata = 32'd0;
		endcase
	end

	dmxe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_stat.full),
		.cmd_push (cmd_push),
		.cmd      (push_cmd)
	);

	dmxe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	dmxe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (!q_stat.empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	// The queue never takes a command while full.
	assert property (@(posedge clk) disable iff (!arst_n) !(q_stat.push && q_stat.full))
		else $error("command pushed into a full queue");

	// The back only retires a command that is present.
	assert property (@(posedge clk) disable iff (!arst_n) q_stat.pop |-> !q_stat.empty)
		else $error("command popped from an empty queue");

	// Every symbol lasts at least one tick.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> out_item.duration != 16'd0)
		else $error("symbol with zero duration");

	// A retired command leaves its final symbol in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.pop |=> out_valid && out_item.last_symbol)
		else $error("command retired without a final symbol");

endmodule

// ===== tb/dmx512_frame_symbol_encoder_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DMX512 frame symbol encoder testbench
// Drives slot items through the valid/ready input and predicts the line
// symbols of every accepted item: break, mark after break, start code and
// data slots, at the programmed durations. Each output symbol is checked
// field by field against the oldest pending prediction. The run covers the
// duration registers at their extremes, items before any frame, a full
// universe, a long output stall and random frame traffic under three idle
// mixes.
// -----------------------------------------------------------------------------
module dmx512_frame_symbol_encoder_tb;

	localparam int          DRAIN_CYCLES = 30;
	localparam int          LONG_HOLD    = 300;
	localparam logic [1:0]  REG_NONE     = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	dmxe_pkg::in_item_t    in_item;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	dmxe_pkg::out_item_t   out_item;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [dmxe_pkg::ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	// Predicted encoder state and duration registers.
	logic        frame_open  = 1'b0;
	int          slots_sent  = 0;
	logic [15:0] break_len   = 16'd176;
	logic [15:0] mab_len     = 16'd12;
	logic [15:0] bit_len     = 16'd4;

	// Symbols predicted and not yet seen at the output.
	dmxe_pkg::out_item_t pending_symbols[$];

	int errors       = 0;
	int items_sent   = 0;
	int syms_checked = 0;
	int cfg_writes   = 0;
	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	int hold_request = 0;
	int hold_taken   = 0;
	int hold_left    = 0;

	dmx512_frame_symbol_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// A zero duration register still gives a one-tick symbol.
	function automatic logic [15:0] ticks_or_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	// Symbol at position idx of a frame: break, mark after break, the start
	// code slot and then the data slot.
	function automatic dmxe_pkg::out_item_t symbol_at(input int idx, input logic [7:0] data,
			input logic last);
		dmxe_pkg::out_item_t s;
		int                  pos;
		logic [7:0]          b;
		s.last_symbol = last;
		if (idx == dmxe_pkg::IDX_BREAK) begin
			s.line_level = 1'b0;
			s.duration   = ticks_or_one(break_len);
		end else if (idx == dmxe_pkg::IDX_MAB) begin
			s.line_level = 1'b1;
			s.duration   = ticks_or_one(mab_len);
		end else begin
			b   = (idx <= dmxe_pkg::IDX_SC_LAST) ? dmxe_pkg::START_CODE : data;
			pos = (idx <= dmxe_pkg::IDX_SC_LAST) ? idx - dmxe_pkg::IDX_SC_FIRST
			                                     : idx - dmxe_pkg::IDX_DT_FIRST;
			s.duration = ticks_or_one(bit_len);
			if (pos == 0) begin
				s.line_level = 1'b0;
			end else if (pos <= 8) begin
				s.line_level = b[pos-1];
			end else begin
				s.line_level = 1'b1;
			end
		end
		return s;
	endfunction

	// Predict the symbols of one accepted item and update the frame state.
	task automatic predict_symbols(input dmxe_pkg::in_item_t it);
		int first;
		int last;
		logic wants_data;
		first = -1;
		last  = -1;
		wants_data = it.frame_start ? !it.header_only : frame_open;
		if (it.frame_start) begin
			frame_open = 1'b1;
			slots_sent = 0;
			first      = dmxe_pkg::IDX_BREAK;
			last       = dmxe_pkg::IDX_SC_LAST;
		end
		if (wants_data && slots_sent < dmxe_pkg::MAX_SLOTS) begin
			if (first < 0) begin
				first = dmxe_pkg::IDX_DT_FIRST;
			end
			last = dmxe_pkg::IDX_DT_LAST;
			slots_sent++;
		end
		if (first >= 0) begin
			for (int i = first; i <= last; i++) begin
				pending_symbols.push_back(symbol_at(i, it.slot_byte, i == last));
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int want, input int got);
		errors++;
		if (errors <= 30) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// Compare one output symbol with the oldest prediction.
	task automatic check_symbol(input dmxe_pkg::out_item_t got);
		dmxe_pkg::out_item_t want;
		if (pending_symbols.size() == 0) begin
			errors++;
			if (errors <= 30) begin
				$display("%0t ns: unexpected symbol, expected none, actual %0b %0d %0b",
					$time, got.line_level, got.duration, got.last_symbol);
			end
		end else begin
			want = pending_symbols.pop_front();
			syms_checked++;
			if (got.line_level !== want.line_level) begin
				report_mismatch("line_level", want.line_level, got.line_level);
			end
			if (got.duration !== want.duration) begin
				report_mismatch("duration", want.duration, got.duration);
			end
			if (got.last_symbol !== want.last_symbol) begin
				report_mismatch("last_symbol", want.last_symbol, got.last_symbol);
			end
		end
	endtask

	// Output is checked before the input item of the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				check_symbol(out_item);
			end
			if (in_valid && in_ready) begin
				predict_symbols(in_item);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_request != hold_taken) begin
			hold_taken = hold_request;
			hold_left  = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Offer one item, with random idle cycles first, and wait until accepted.
	task automatic send_slot(input logic [7:0] b, input logic fs, input logic ho);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{slot_byte: b, frame_start: fs, header_only: ho};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering items and wait until every predicted symbol has arrived.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_symbols.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= dmxe_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= {16'($urandom_range(0, 65535)), val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			dmxe_pkg::REG_BREAK: break_len = val;
			dmxe_pkg::REG_MAB:   mab_len   = val;
			dmxe_pkg::REG_BIT:   bit_len   = val;
			default:             ;
		endcase
		cfg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic reg_check(input logic [1:0] idx, input logic [15:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= dmxe_pkg::ADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[15:0] !== want) begin
			report_mismatch("register read", want, prdata[15:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_regs();
		reg_check(dmxe_pkg::REG_BREAK, break_len);
		reg_check(dmxe_pkg::REG_MAB, mab_len);
		reg_check(dmxe_pkg::REG_BIT, bit_len);
	endtask

	task automatic set_durations(input logic [15:0] brk, input logic [15:0] mab,
			input logic [15:0] bt);
		reg_write(dmxe_pkg::REG_BREAK, brk);
		reg_write(dmxe_pkg::REG_MAB, mab);
		reg_write(dmxe_pkg::REG_BIT, bt);
		check_regs();
	endtask

	// Duration values weighted toward the extremes.
	function automatic logic [15:0] pick_ticks();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 16'd0;
		end else if (r == 1) begin
			return 16'd1;
		end else if (r == 2) begin
			return 16'hFFFF;
		end
		return 16'($urandom_range(1, 65535));
	endfunction

	// Items before the first frame start are ignored; then a header-only frame.
	task automatic test_idle_before_frame();
		tx_idle_pct = 21;
		rx_idle_pct = 80;
		check_regs();
		send_slot(8'h00, 1'b0, 1'b0);
		send_slot(8'hFF, 1'b0, 1'b1);
		send_slot(8'h5A, 1'b0, 1'b0);
		wait_drained();
		send_slot(8'h77, 1'b1, 1'b1);
		wait_drained();
	endtask

	// Frame starts with and without data, byte extremes, header_only on data.
	task automatic test_frame_basics();
		send_slot(8'hFF, 1'b1, 1'b0);
		send_slot(8'h00, 1'b0, 1'b0);
		send_slot(8'hA5, 1'b0, 1'b0);
		send_slot(8'h5A, 1'b0, 1'b1);
		send_slot(8'h01, 1'b0, 1'b0);
		send_slot(8'h80, 1'b0, 1'b0);
		send_slot(8'h3C, 1'b1, 1'b1);
		send_slot(8'hC3, 1'b1, 1'b0);
		wait_drained();
	endtask

	// Zero, one and full-scale durations, and a write outside the register map.
	task automatic test_register_extremes();
		tx_idle_pct = 80;
		rx_idle_pct = 21;
		set_durations(16'd0, 16'd0, 16'd0);
		send_slot(8'h96, 1'b1, 1'b0);
		send_slot(8'h69, 1'b0, 1'b0);
		wait_drained();
		set_durations(16'd1, 16'd1, 16'd1);
		send_slot(8'h0F, 1'b1, 1'b0);
		wait_drained();
		set_durations(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_slot(8'hF0, 1'b1, 1'b0);
		send_slot(8'hAA, 1'b0, 1'b0);
		wait_drained();
		reg_write(REG_NONE, 16'h1234);
		check_regs();
		set_durations(16'd176, 16'd12, 16'd4);
		send_slot(8'h55, 1'b1, 1'b0);
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while items keep coming.
	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request++;
		for (int i = 0; i < 12; i++) begin
			send_slot(8'($urandom_range(0, 255)), 1'(i % 5 == 0), 1'b0);
		end
		wait_drained();
	endtask

	// Fill the universe, check that surplus slots vanish, then start again.
	task automatic test_universe_full();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_slot(8'h11, 1'b1, 1'b0);
		for (int i = 1; i < dmxe_pkg::MAX_SLOTS + 3; i++) begin
			send_slot(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
		end
		send_slot(8'h22, 1'b0, 1'b1);
		send_slot(8'h33, 1'b1, 1'b1);
		send_slot(8'h44, 1'b0, 1'b0);
		wait_drained();
	endtask

	// Mostly well-formed frames with random content, some random noise items.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
		int         counted;
		logic       fs;
		logic       ho;
		logic [7:0] b;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		counted     = 0;
		while (counted < n_items) begin
			b = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 5) begin
				fs = 1'($urandom_range(0, 1));
				ho = 1'($urandom_range(0, 1));
			end else begin
				fs = !frame_open || ($urandom_range(0, 99) < 7);
				ho = fs ? ($urandom_range(0, 99) < 20) : 1'($urandom_range(0, 1));
			end
			if (fs || frame_open) begin
				counted++;
			end
			send_slot(b, fs, ho);
		end
		wait_drained();
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_idle_before_frame();
		test_frame_basics();
		test_register_extremes();
		test_output_stall();
		test_universe_full();

		set_durations(pick_ticks(), pick_ticks(), pick_ticks());
		test_random_traffic(21, 80, 25);
		set_durations(pick_ticks(), pick_ticks(), pick_ticks());
		test_random_traffic(80, 21, 25);
		set_durations(pick_ticks(), pick_ticks(), pick_ticks());
		test_random_traffic(0, 0, 25);

		$display("Run covered %0d items, %0d symbols checked, %0d register writes,",
			items_sent, syms_checked, cfg_writes);
		$display("including a full universe, a long output stall and three idle mixes.");
		if (errors == 0 && pending_symbols.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10_000_000;
		$display("Timeout with %0d symbols still pending.", pending_symbols.size());
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dmxe_pkg.sv
src/dmxe_front.sv
src/dmxe_queue.sv
src/dmxe_back.sv
src/dmx512_frame_symbol_encoder.sv
tb/dmx512_frame_symbol_encoder_tb.sv
